// ===== hw/rtl/fwr_pkg.sv =====
// shared types and constants for the full-weighting restriction block
package fwr_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    // configuration register widths
    localparam int FINE_X_W   = 11;
    localparam int FINE_YZ_W  = 7;
    localparam int COARSE_X_W = 10;
    localparam int COARSE_YZ_W = 6;

    // configuration reset values
    localparam logic [FINE_X_W-1:0]    FINE_X_RST   = 11'd33;
    localparam logic [FINE_YZ_W-1:0]   FINE_YZ_RST  = 7'd33;
    localparam logic [COARSE_X_W-1:0]  COARSE_X_RST = 10'd17;
    localparam logic [COARSE_YZ_W-1:0] COARSE_YZ_RST = 6'd17;

    // result index widths
    localparam int OUT_X_W  = 9;
    localparam int OUT_YZ_W = 5;

    // weights sum to 64, so the exact sum is shifted by six
    localparam int WEIGHT_SHIFT = 6;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FINE_DIM_X   = 3'd0,
        REG_FINE_DIM_Y   = 3'd1,
        REG_FINE_DIM_Z   = 3'd2,
        REG_COARSE_DIM_X = 3'd3,
        REG_COARSE_DIM_Y = 3'd4,
        REG_COARSE_DIM_Z = 3'd5
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_DRAIN = 2'd2,
        ST_HOLD  = 2'd3
    } state_t;

    // one accumulate step, aligned with the registered read data
    typedef struct packed {
        logic       add;
        logic       first;
        logic [1:0] shift;
    } acc_cmd_t;

    // result load into the output register
    typedef struct packed {
        logic                load;
        logic [OUT_X_W-1:0]  cx;
        logic [OUT_YZ_W-1:0] cy;
        logic [OUT_YZ_W-1:0] cz;
        logic                last;
    } load_t;

endpackage

// ===== hw/rtl/fwr_store.sv =====
// three-plane sample store, one write port and one registered read port
module fwr_store #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 14,
    parameter int DEPTH  = 12288
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/fwr_acc.sv =====
// shift-and-add accumulator and result output register
module fwr_acc #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fwr_pkg::acc_cmd_t              cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] rd_data,
    input  fwr_pkg::load_t                 load,
    input  logic                           result_stall,
    output logic                           result_valid,
    output logic signed [SAMPLE_WIDTH-1:0] coarse_value,
    output logic [fwr_pkg::OUT_X_W-1:0]    coarse_x,
    output logic [fwr_pkg::OUT_YZ_W-1:0]   coarse_y,
    output logic [fwr_pkg::OUT_YZ_W-1:0]   coarse_z,
    output logic                           last_point
);

    localparam int ACC_W = SAMPLE_WIDTH + fwr_pkg::WEIGHT_SHIFT;

    logic signed [ACC_W-1:0]        term;
    logic signed [ACC_W-1:0]        sum_reg;
    logic signed [ACC_W-1:0]        sum_next;
    logic                           valid_reg;
    logic                           valid_next;
    logic [SAMPLE_WIDTH-1:0]        value_reg;
    logic [fwr_pkg::OUT_X_W-1:0]    cx_reg;
    logic [fwr_pkg::OUT_YZ_W-1:0]   cy_reg;
    logic [fwr_pkg::OUT_YZ_W-1:0]   cz_reg;
    logic                           last_reg;

    // weighted term: sign-extended sample times 1, 2, 4 or 8
    always_comb
    begin
        term = {{fwr_pkg::WEIGHT_SHIFT{rd_data[SAMPLE_WIDTH-1]}}, rd_data} <<< cmd.shift;
        sum_next = sum_reg;
        if (cmd.add)
        begin
            if (cmd.first)
            begin
                sum_next = term;
            end
            else
            begin
                sum_next = sum_reg + term;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    // output valid: set on load, cleared on transfer
    always_comb
    begin
        valid_next = valid_reg;
        if (load.load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // output payload, arithmetic shift by six keeps the upper bits
    always_ff @(posedge clk)
    begin
        if (load.load)
        begin
            value_reg <= sum_reg[ACC_W-1:fwr_pkg::WEIGHT_SHIFT];
            cx_reg    <= load.cx;
            cy_reg    <= load.cy;
            cz_reg    <= load.cz;
            last_reg  <= load.last;
        end
    end

    assign result_valid = valid_reg;
    assign coarse_value = value_reg;
    assign coarse_x     = cx_reg;
    assign coarse_y     = cy_reg;
    assign coarse_z     = cz_reg;
    assign last_point   = last_reg;

endmodule

// ===== hw/rtl/fwr_ctrl.sv =====
// configuration, raster position, store addressing and read sequencer
module fwr_ctrl #(
    parameter int MAX_FINE_OUTER      = 1024,
    parameter int MAX_FINE_PLANE_SIDE = 64,
    parameter int SAMPLE_WIDTH        = 32,
    parameter int ADDR_W              = 14
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [fwr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fwr_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  logic [SAMPLE_WIDTH-1:0]            sample_value,
    input  logic                               result_valid,
    input  logic                               result_stall,
    output logic                               wr_en,
    output logic [ADDR_W-1:0]                  wr_addr,
    output logic [SAMPLE_WIDTH-1:0]            wr_data,
    output logic                               rd_en,
    output logic [ADDR_W-1:0]                  rd_addr,
    output fwr_pkg::acc_cmd_t                  acc_cmd,
    output fwr_pkg::load_t                     load
);

    localparam int XW  = $clog2(MAX_FINE_OUTER);
    localparam int XCW = $clog2(MAX_FINE_OUTER + 1);
    localparam int PW  = $clog2(MAX_FINE_PLANE_SIDE);
    localparam int PCW = $clog2(MAX_FINE_PLANE_SIDE + 1);

    // configuration registers
    logic [fwr_pkg::FINE_X_W-1:0]    fine_dim_x_reg;
    logic [fwr_pkg::FINE_YZ_W-1:0]   fine_dim_y_reg;
    logic [fwr_pkg::FINE_YZ_W-1:0]   fine_dim_z_reg;
    logic [fwr_pkg::COARSE_X_W-1:0]  coarse_dim_x_reg;
    logic [fwr_pkg::COARSE_YZ_W-1:0] coarse_dim_y_reg;
    logic [fwr_pkg::COARSE_YZ_W-1:0] coarse_dim_z_reg;
    logic                            restart;

    // position of the next sample and its plane slot
    logic [XW-1:0] x_reg, x_next;
    logic [PW-1:0] y_reg, y_next;
    logic [PW-1:0] z_reg, z_next;
    logic [1:0]    slot_reg, slot_next;

    // sequencer
    fwr_pkg::state_t state_reg, state_next;
    logic [1:0]      i_reg, i_next;
    logic [1:0]      j_reg, j_next;
    logic [1:0]      k_reg, k_next;
    logic [PW-1:0]   ybase_reg, ybase_next;
    logic [PW-1:0]   zbase_reg, zbase_next;
    logic [1:0]      sbase_reg, sbase_next;
    fwr_pkg::acc_cmd_t cmd_reg, cmd_next;

    // coarse point captured with the completing sample
    logic [fwr_pkg::OUT_X_W-1:0]  cx_reg, cx_next;
    logic [fwr_pkg::OUT_YZ_W-1:0] cy_reg, cy_next;
    logic [fwr_pkg::OUT_YZ_W-1:0] cz_reg, cz_next;
    logic                         last_reg, last_next;

    logic [XCW-1:0] fdx;
    logic [PCW-1:0] fdy;
    logic [PCW-1:0] fdz;
    logic           accept;
    logic           emit;
    logic [XW-1:0]  cx;
    logic [PW-1:0]  cy;
    logic [PW-1:0]  cz;
    logic [2:0]     slot_sum;
    logic [1:0]     rd_slot;

    // configuration writes, any listed register restarts the grid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fine_dim_x_reg   <= fwr_pkg::FINE_X_RST;
            fine_dim_y_reg   <= fwr_pkg::FINE_YZ_RST;
            fine_dim_z_reg   <= fwr_pkg::FINE_YZ_RST;
            coarse_dim_x_reg <= fwr_pkg::COARSE_X_RST;
            coarse_dim_y_reg <= fwr_pkg::COARSE_YZ_RST;
            coarse_dim_z_reg <= fwr_pkg::COARSE_YZ_RST;
        end
        else if (cfg_wr_en)
        begin
            case (fwr_pkg::cfg_reg_t'(cfg_index))
                fwr_pkg::REG_FINE_DIM_X:
                    fine_dim_x_reg <= cfg_wr_data;
                fwr_pkg::REG_FINE_DIM_Y:
                    fine_dim_y_reg <= cfg_wr_data[fwr_pkg::FINE_YZ_W-1:0];
                fwr_pkg::REG_FINE_DIM_Z:
                    fine_dim_z_reg <= cfg_wr_data[fwr_pkg::FINE_YZ_W-1:0];
                fwr_pkg::REG_COARSE_DIM_X:
                    coarse_dim_x_reg <= cfg_wr_data[fwr_pkg::COARSE_X_W-1:0];
                fwr_pkg::REG_COARSE_DIM_Y:
                    coarse_dim_y_reg <= cfg_wr_data[fwr_pkg::COARSE_YZ_W-1:0];
                fwr_pkg::REG_COARSE_DIM_Z:
                    coarse_dim_z_reg <= cfg_wr_data[fwr_pkg::COARSE_YZ_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (fwr_pkg::cfg_reg_t'(cfg_index))
            fwr_pkg::REG_FINE_DIM_X,
            fwr_pkg::REG_FINE_DIM_Y,
            fwr_pkg::REG_FINE_DIM_Z,
            fwr_pkg::REG_COARSE_DIM_X,
            fwr_pkg::REG_COARSE_DIM_Y,
            fwr_pkg::REG_COARSE_DIM_Z:
                restart = cfg_wr_en;
            default:
                restart = 1'b0;
        endcase
    end

    // effective fine dimensions: zero counts as one, oversize as the maximum
    always_comb
    begin
        if (fine_dim_x_reg == '0)
            fdx = XCW'(1);
        else if (32'(fine_dim_x_reg) > 32'(MAX_FINE_OUTER))
            fdx = XCW'(MAX_FINE_OUTER);
        else
            fdx = XCW'(fine_dim_x_reg);

        if (fine_dim_y_reg == '0)
            fdy = PCW'(1);
        else if (32'(fine_dim_y_reg) > 32'(MAX_FINE_PLANE_SIDE))
            fdy = PCW'(MAX_FINE_PLANE_SIDE);
        else
            fdy = PCW'(fine_dim_y_reg);

        if (fine_dim_z_reg == '0)
            fdz = PCW'(1);
        else if (32'(fine_dim_z_reg) > 32'(MAX_FINE_PLANE_SIDE))
            fdz = PCW'(MAX_FINE_PLANE_SIDE);
        else
            fdz = PCW'(fine_dim_z_reg);
    end

    // does the incoming sample complete an interior coarse point
    always_comb
    begin
        cx = x_reg >> 1;
        cy = y_reg >> 1;
        cz = z_reg >> 1;
        emit = x_reg[0] && y_reg[0] && z_reg[0]
            && (32'(x_reg) >= 32'd3) && (32'(y_reg) >= 32'd3) && (32'(z_reg) >= 32'd3)
            && (32'(cx) + 32'd2 <= 32'(coarse_dim_x_reg))
            && (32'(cy) + 32'd2 <= 32'(coarse_dim_y_reg))
            && (32'(cz) + 32'd2 <= 32'(coarse_dim_z_reg));
    end

    // read slot for plane offset i: x-2, x-1, x
    always_comb
    begin
        slot_sum = 3'(sbase_reg) + 3'd1 + 3'(i_reg);
        if (slot_sum >= 3'd3)
            rd_slot = 2'(slot_sum - 3'd3);
        else
            rd_slot = 2'(slot_sum);
    end

    // next state, position and store access
    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        slot_next  = slot_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        ybase_next = ybase_reg;
        zbase_next = zbase_reg;
        sbase_next = sbase_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cz_next    = cz_reg;
        last_next  = last_reg;
        cmd_next   = '0;
        load       = '0;
        load.cx    = cx_reg;
        load.cy    = cy_reg;
        load.cz    = cz_reg;
        load.last  = last_reg;
        sample_stall = 1'b1;
        accept     = 1'b0;
        rd_en      = 1'b0;

        case (state_reg)
            fwr_pkg::ST_IDLE:
            begin
                sample_stall = 1'b0;
                accept = sample_valid;
                if (sample_valid)
                begin
                    // capture the coarse point and start the reads
                    if (emit)
                    begin
                        state_next = fwr_pkg::ST_READ;
                        i_next     = 2'd0;
                        j_next     = 2'd0;
                        k_next     = 2'd0;
                        ybase_next = y_reg;
                        zbase_next = z_reg;
                        sbase_next = slot_reg;
                        cx_next    = fwr_pkg::OUT_X_W'(cx);
                        cy_next    = fwr_pkg::OUT_YZ_W'(cy);
                        cz_next    = fwr_pkg::OUT_YZ_W'(cz);
                        last_next  = (32'(cx) + 32'd2 == 32'(coarse_dim_x_reg))
                            && (32'(cy) + 32'd2 == 32'(coarse_dim_y_reg))
                            && (32'(cz) + 32'd2 == 32'(coarse_dim_z_reg));
                    end
                    // raster advance, z innermost
                    if (PCW'(z_reg) + PCW'(1) >= fdz)
                    begin
                        z_next = '0;
                        if (PCW'(y_reg) + PCW'(1) >= fdy)
                        begin
                            y_next = '0;
                            if (XCW'(x_reg) + XCW'(1) >= fdx)
                            begin
                                x_next    = '0;
                                slot_next = 2'd0;
                            end
                            else
                            begin
                                x_next    = x_reg + XW'(1);
                                slot_next = (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            y_next = y_reg + PW'(1);
                        end
                    end
                    else
                    begin
                        z_next = z_reg + PW'(1);
                    end
                end
            end

            fwr_pkg::ST_READ:
            begin
                rd_en = 1'b1;
                cmd_next.add   = 1'b1;
                cmd_next.first = (i_reg == 2'd0) && (j_reg == 2'd0) && (k_reg == 2'd0);
                cmd_next.shift = 2'(i_reg == 2'd1) + 2'(j_reg == 2'd1) + 2'(k_reg == 2'd1);
                if (k_reg == 2'd2)
                begin
                    k_next = 2'd0;
                    if (j_reg == 2'd2)
                    begin
                        j_next = 2'd0;
                        if (i_reg == 2'd2)
                        begin
                            state_next = fwr_pkg::ST_DRAIN;
                        end
                        else
                        begin
                            i_next = i_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 2'd1;
                    end
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end

            fwr_pkg::ST_DRAIN:
            begin
                // last term is added at the end of this cycle
                state_next = fwr_pkg::ST_HOLD;
            end

            fwr_pkg::ST_HOLD:
            begin
                // load once the output register is free
                if (!result_valid || !result_stall)
                begin
                    load.load  = 1'b1;
                    state_next = fwr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = fwr_pkg::ST_IDLE;
            end
        endcase

        if (restart)
        begin
            x_next    = '0;
            y_next    = '0;
            z_next    = '0;
            slot_next = 2'd0;
        end
    end

    // store ports
    assign wr_en   = accept;
    assign wr_addr = {slot_reg, y_reg, z_reg};
    assign wr_data = sample_value;
    assign rd_addr = {rd_slot,
                      ybase_reg - PW'(2) + PW'(j_reg),
                      zbase_reg - PW'(2) + PW'(k_reg)};
    assign acc_cmd = cmd_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fwr_pkg::ST_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            slot_reg  <= 2'd0;
            i_reg     <= 2'd0;
            j_reg     <= 2'd0;
            k_reg     <= 2'd0;
            cmd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            slot_reg  <= slot_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            cmd_reg   <= cmd_next;
        end
    end

    // captured coordinates, no reset needed
    always_ff @(posedge clk)
    begin
        ybase_reg <= ybase_next;
        zbase_reg <= zbase_next;
        sbase_reg <= sbase_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        last_reg  <= last_next;
    end

endmodule

// ===== hw/rtl/multigrid_full_weighting_restrict.sv =====
// Full-weighting 3-D restriction: fine samples stream in raster order (x outermost,
// z innermost) and each interior coarse point comes out as the 27-point weighted
// average (8/4/2/1 over 64, floor). A sample that completes no coarse point is
// taken without stalling the input. A sample that completes one stalls the input
// until its result is loaded: the 27 neighbors are read one per cycle through the
// single read port of the three-plane store and summed by one shift-and-add unit,
// then a drain step and a load into the output register, which waits while that
// register is still held by a stalled transfer. The store has no clearing pass
// after reset; a write to one of the six dimension registers restarts the grid
// at the origin.
module multigrid_full_weighting_restrict #(
    parameter int MAX_FINE_OUTER      = 1024,
    parameter int MAX_FINE_PLANE_SIDE = 64,
    parameter int SAMPLE_WIDTH        = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [fwr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fwr_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]  sample_value,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic signed [SAMPLE_WIDTH-1:0]  coarse_value,
    output logic [fwr_pkg::OUT_X_W-1:0]     coarse_x,
    output logic [fwr_pkg::OUT_YZ_W-1:0]    coarse_y,
    output logic [fwr_pkg::OUT_YZ_W-1:0]    coarse_z,
    output logic                            last_point
);

    localparam int PW     = $clog2(MAX_FINE_PLANE_SIDE);
    localparam int ADDR_W = 2 + 2 * PW;
    localparam int DEPTH  = 3 * (1 << (2 * PW));

    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [SAMPLE_WIDTH-1:0] wr_data;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic [SAMPLE_WIDTH-1:0] rd_data;
    fwr_pkg::acc_cmd_t       acc_cmd;
    fwr_pkg::load_t          load;

    // sequencer
    fwr_ctrl #(
        .MAX_FINE_OUTER      (MAX_FINE_OUTER),
        .MAX_FINE_PLANE_SIDE (MAX_FINE_PLANE_SIDE),
        .SAMPLE_WIDTH        (SAMPLE_WIDTH),
        .ADDR_W              (ADDR_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_value (sample_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .acc_cmd      (acc_cmd),
        .load         (load)
    );

    // three-plane store
    fwr_store #(
        .DATA_W (SAMPLE_WIDTH),
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shared accumulator and output register
    fwr_acc #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_acc (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (acc_cmd),
        .rd_data      (rd_data),
        .load         (load),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .coarse_value (coarse_value),
        .coarse_x     (coarse_x),
        .coarse_y     (coarse_y),
        .coarse_z     (coarse_z),
        .last_point   (last_point)
    );

endmodule

// ===== hw/rtl/fwr_checker.sv =====
// port-level assertions for the restriction block and their bind
module fwr_checker #(
    parameter int SAMPLE_WIDTH = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          sample_stall,
    input logic                          result_valid,
    input logic                          result_stall,
    input logic [SAMPLE_WIDTH-1:0]       coarse_value,
    input logic [fwr_pkg::OUT_X_W-1:0]   coarse_x,
    input logic [fwr_pkg::OUT_YZ_W-1:0]  coarse_y,
    input logic [fwr_pkg::OUT_YZ_W-1:0]  coarse_z,
    input logic                          last_point
);

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(coarse_value)
            && $stable(coarse_x) && $stable(coarse_y) && $stable(coarse_z)
            && $stable(last_point))
    else $error("stalled result changed");

    // coarse points on the zero boundary are never emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> coarse_x != '0 && coarse_y != '0 && coarse_z != '0)
    else $error("result on a coarse boundary index");

    // a new result is only loaded while the input side is held
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_stall))
    else $error("result appeared without a summing pass");

    // the input is still held in the drain step before a result rises
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_stall, 2))
    else $error("summing pass shorter than expected");

endmodule

bind multigrid_full_weighting_restrict fwr_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_fwr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .coarse_value (coarse_value),
    .coarse_x     (coarse_x),
    .coarse_y     (coarse_y),
    .coarse_z     (coarse_z),
    .last_point   (last_point)
);

// ===== bench/tb_top.sv =====
// self-checking testbench for the 27-point full-weighting restriction block
`timescale 1ns / 1ps

module tb_top;

    localparam int OUTER_LIMIT   = 1024;
    localparam int PLANE_SIDE    = 64;
    localparam int SAMPLE_WIDTH  = 32;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 200;
    localparam int RANDOM_POINTS = 4;
    // at most about 4k samples, each with its idle gap, plus the summing passes and
    // the result stalls for the points, with a wide margin
    localparam longint LIMIT_NS  = 64'd50_000_000;

    // indexes past the register list, writes there are ignored
    localparam logic [fwr_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [fwr_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = 32'sh7fff_ffff;
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = 32'sh8000_0000;

    typedef enum {FILL_MAX, FILL_MIN, FILL_ALT, FILL_RANDOM} fill_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0]  value;
        logic [fwr_pkg::OUT_X_W-1:0]     cx;
        logic [fwr_pkg::OUT_YZ_W-1:0]    cy;
        logic [fwr_pkg::OUT_YZ_W-1:0]    cz;
        logic                            is_last;
    } coarse_point_t;

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [fwr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [fwr_pkg::CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                            sample_valid = 1'b0;
    logic                            sample_stall;
    logic signed [SAMPLE_WIDTH-1:0]  sample_value = '0;
    logic                            result_valid;
    logic                            result_stall = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0]  coarse_value;
    logic [fwr_pkg::OUT_X_W-1:0]     coarse_x;
    logic [fwr_pkg::OUT_YZ_W-1:0]    coarse_y;
    logic [fwr_pkg::OUT_YZ_W-1:0]    coarse_z;
    logic                            last_point;

    // pending stimulus and predicted coarse points
    logic signed [SAMPLE_WIDTH-1:0] pending_samples[$];
    coarse_point_t                  expected_points[$];
    int                             samples_queued = 0;
    int                             samples_accepted = 0;
    int                             points_predicted = 0;
    int                             error_count = 0;

    // handshake bookkeeping between the edges
    bit                             sample_taken = 1'b0;
    bit                             quiet = 1'b0;
    int                             send_gap = 0;
    int                             stall_left = 0;

    // predictor state: register copies, raster position, three-plane ring
    int                             fine_x = 33;
    int                             fine_y = 33;
    int                             fine_z = 33;
    int                             coarse_x_dim = 17;
    int                             coarse_y_dim = 17;
    int                             coarse_z_dim = 17;
    int                             grid_x = 0;
    int                             grid_y = 0;
    int                             grid_z = 0;
    logic signed [SAMPLE_WIDTH-1:0] plane_ring [3*PLANE_SIDE*PLANE_SIDE];

    multigrid_full_weighting_restrict #(
        .MAX_FINE_OUTER      (OUTER_LIMIT),
        .MAX_FINE_PLANE_SIDE (PLANE_SIDE),
        .SAMPLE_WIDTH        (SAMPLE_WIDTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_value (sample_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .coarse_value (coarse_value),
        .coarse_x     (coarse_x),
        .coarse_y     (coarse_y),
        .coarse_z     (coarse_z),
        .last_point   (last_point)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // zero means one, oversize means the limit
    function automatic int dim_in_use(input int d, input int limit);
        if (d == 0)
            return 1;
        return (d > limit) ? limit : d;
    endfunction

    // slot of the ring is the outer index mod 3
    function automatic int ring_addr(input int x, input int y, input int z);
        return ((x % 3) * PLANE_SIDE + y) * PLANE_SIDE + z;
    endfunction

    // mostly short idles, some medium, a few long, none in quiet stretches
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_WIDTH'(int'($urandom_range(0, 200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_fine();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 3);
        return $urandom_range(4, 9);
    endfunction

    // mostly a coarse size that fits, sometimes too small or too big
    function automatic int pick_coarse(input int f);
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, f + 4);
        return $urandom_range(3, (f < 4) ? 3 : (f + 2) / 2);
    endfunction

    // store one fine sample and work out the coarse point it completes
    task automatic restrict_sample(input logic signed [SAMPLE_WIDTH-1:0] sample);
        int            span_x, span_y, span_z;
        int            x, y, z, cx, cy, cz, i, j, k, w;
        longint        acc;
        coarse_point_t pt;
        span_x = dim_in_use(fine_x, OUTER_LIMIT);
        span_y = dim_in_use(fine_y, PLANE_SIDE);
        span_z = dim_in_use(fine_z, PLANE_SIDE);
        x = (grid_x >= span_x) ? 0 : grid_x;
        y = (grid_y >= span_y) ? 0 : grid_y;
        z = (grid_z >= span_z) ? 0 : grid_z;
        plane_ring[ring_addr(x, y, z)] = sample;

        // odd corner past the first cell closes the cube around (x-1, y-1, z-1)
        if (x % 2 == 1 && y % 2 == 1 && z % 2 == 1 && x >= 3 && y >= 3 && z >= 3)
        begin
            cx = (x - 1) / 2;
            cy = (y - 1) / 2;
            cz = (z - 1) / 2;
            if (cx + 2 <= coarse_x_dim && cy + 2 <= coarse_y_dim && cz + 2 <= coarse_z_dim)
            begin
                acc = 0;
                for (i = -1; i <= 1; i++)
                    for (j = -1; j <= 1; j++)
                        for (k = -1; k <= 1; k++)
                        begin
                            w = (i == 0 ? 2 : 1) * (j == 0 ? 2 : 1) * (k == 0 ? 2 : 1);
                            acc += w * longint'(plane_ring[ring_addr(2 * cx + i,
                                2 * cy + j, 2 * cz + k)]);
                        end
                // floor division by the weight total
                pt.value   = SAMPLE_WIDTH'(acc >>> fwr_pkg::WEIGHT_SHIFT);
                pt.cx      = fwr_pkg::OUT_X_W'(cx);
                pt.cy      = fwr_pkg::OUT_YZ_W'(cy);
                pt.cz      = fwr_pkg::OUT_YZ_W'(cz);
                pt.is_last = (cx + 2 == coarse_x_dim) && (cy + 2 == coarse_y_dim)
                             && (cz + 2 == coarse_z_dim);
                expected_points.push_back(pt);
                points_predicted++;
            end
        end

        // raster advance with wrap to a new grid
        z++;
        if (z >= span_z)
        begin
            z = 0;
            y++;
            if (y >= span_y)
            begin
                y = 0;
                x++;
                if (x >= span_x)
                    x = 0;
            end
        end
        grid_x = x;
        grid_y = y;
        grid_z = z;
    endtask

    // accepted transfers on both channels
    always @(posedge clk)
    begin : monitor_blk
        coarse_point_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    $display("%0t: result with nothing expected: value %0d at (%0d,%0d,%0d)",
                             $time, coarse_value, coarse_x, coarse_y, coarse_z);
                    error_count++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (coarse_value !== want.value)
                    begin
                        $display("%0t: coarse_value expected %0d got %0d",
                                 $time, want.value, coarse_value);
                        error_count++;
                    end
                    if (coarse_x !== want.cx)
                    begin
                        $display("%0t: coarse_x expected %0d got %0d", $time, want.cx, coarse_x);
                        error_count++;
                    end
                    if (coarse_y !== want.cy)
                    begin
                        $display("%0t: coarse_y expected %0d got %0d", $time, want.cy, coarse_y);
                        error_count++;
                    end
                    if (coarse_z !== want.cz)
                    begin
                        $display("%0t: coarse_z expected %0d got %0d", $time, want.cz, coarse_z);
                        error_count++;
                    end
                    if (last_point !== want.is_last)
                    begin
                        $display("%0t: last_point expected %0d got %0d",
                                 $time, want.is_last, last_point);
                        error_count++;
                    end
                end
            end
            if (sample_valid && !sample_stall)
            begin
                restrict_sample(sample_value);
                samples_accepted++;
                sample_taken = 1'b1;
            end
        end
    end

    // sample driver and result stall generator
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 299) == 0)
                quiet = !quiet;

            if (!sample_valid || sample_taken)
            begin
                sample_taken = 1'b0;
                if (send_gap > 0)
                begin
                    send_gap--;
                    sample_valid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    sample_valid <= 1'b1;
                    sample_value <= pending_samples.pop_front();
                    send_gap = idle_length();
                end
                else
                    sample_valid <= 1'b0;
            end

            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                result_stall <= 1'b0;
                if (!quiet && $urandom_range(0, 3) == 0)
                    stall_left = idle_length();
            end
        end
    end

    // wait until every sample is taken and every point is out, then let the block settle
    task automatic wait_drained();
        int waited;
        waited = 0;
        while ((samples_accepted != samples_queued || expected_points.size() != 0)
               && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            if (samples_accepted == samples_queued)
                waited++;
        end
        if (expected_points.size() != 0)
        begin
            $display("%0t: %0d results missing, next expected value %0d at (%0d,%0d,%0d)",
                     $time, expected_points.size(), expected_points[0].value,
                     expected_points[0].cx, expected_points[0].cy, expected_points[0].cz);
            error_count++;
            expected_points.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // one register write; valid indexes restart the grid
    task automatic write_reg(input logic [fwr_pkg::CFG_INDEX_W-1:0] idx, input int value);
        int data;
        data = value & 'h7ff;
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data[fwr_pkg::CFG_DATA_W-1:0];
        case (idx)
            fwr_pkg::REG_FINE_DIM_X:   fine_x       = data & 'h7ff;
            fwr_pkg::REG_FINE_DIM_Y:   fine_y       = data & 'h7f;
            fwr_pkg::REG_FINE_DIM_Z:   fine_z       = data & 'h7f;
            fwr_pkg::REG_COARSE_DIM_X: coarse_x_dim = data & 'h3ff;
            fwr_pkg::REG_COARSE_DIM_Y: coarse_y_dim = data & 'h3f;
            fwr_pkg::REG_COARSE_DIM_Z: coarse_z_dim = data & 'h3f;
            default: ;
        endcase
        if (idx <= fwr_pkg::REG_COARSE_DIM_Z)
        begin
            grid_x = 0;
            grid_y = 0;
            grid_z = 0;
        end
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_dims(input int fx, input int fy, input int fz,
                              input int cx, input int cy, input int cz);
        wait_drained();
        write_reg(fwr_pkg::REG_FINE_DIM_X, fx);
        write_reg(fwr_pkg::REG_FINE_DIM_Y, fy);
        write_reg(fwr_pkg::REG_FINE_DIM_Z, fz);
        write_reg(fwr_pkg::REG_COARSE_DIM_X, cx);
        write_reg(fwr_pkg::REG_COARSE_DIM_Y, cy);
        write_reg(fwr_pkg::REG_COARSE_DIM_Z, cz);
    endtask

    // queue samples at the rising edge so the driver sees them next falling edge
    task automatic queue_samples(input int count, input fill_t fill);
        int n;
        @(posedge clk);
        for (n = 0; n < count; n++)
            case (fill)
                FILL_MAX:  pending_samples.push_back(SAMPLE_MAX);
                FILL_MIN:  pending_samples.push_back(SAMPLE_MIN);
                FILL_ALT:  pending_samples.push_back(n % 2 ? SAMPLE_MAX : SAMPLE_MIN);
                default:   pending_samples.push_back(pick_sample());
            endcase
        samples_queued += count;
    endtask

    // stimulus sequence
    initial
    begin
        int fx, fy, fz, cdx, cdy, cdz;
        int grid, count, split, random_items, points_before;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // smallest grid with one point: full-scale positive, negative, alternating
        apply_dims(4, 4, 4, 3, 3, 3);
        queue_samples(64, FILL_MAX);
        queue_samples(64, FILL_MIN);
        queue_samples(64, FILL_ALT);

        // zero dimensions act as one, nothing comes out
        apply_dims(0, 0, 0, 0, 0, 0);
        queue_samples(12, FILL_RANDOM);

        // coarse grid larger than the fine grid allows, no last point
        apply_dims(7, 7, 7, 10, 10, 10);
        queue_samples(200, FILL_RANDOM);
        wait_drained();
        write_reg(REG_SPARE_LO, $urandom_range(0, 2047));
        write_reg(REG_SPARE_HI, $urandom_range(0, 2047));
        queue_samples(100, FILL_RANDOM);
        wait_drained();
        // rewrite of a live register restarts mid-grid
        write_reg(fwr_pkg::REG_COARSE_DIM_Z, 10);
        queue_samples(150, FILL_RANDOM);

        // middle axis clamped to the plane side, coarse x and y registers at their top
        apply_dims(4, 127, 4, 1023, 63, 3);
        queue_samples(3 * 64 * 4 + 16, FILL_RANDOM);

        // outer axis register above its limit, coarse outer size set to 512
        apply_dims(2047, 4, 4, 512, 3, 3);
        queue_samples(100, FILL_RANDOM);

        // random small grids until enough samples and points have gone through
        random_items = 0;
        points_before = points_predicted;
        while (random_items < RANDOM_ITEMS || points_predicted - points_before < RANDOM_POINTS)
        begin
            fx = pick_fine();
            fy = pick_fine();
            fz = pick_fine();
            cdx = pick_coarse(fx);
            cdy = pick_coarse(fy);
            cdz = pick_coarse(fz);
            apply_dims(fx, fy, fz, cdx, cdy, cdz);
            grid = dim_in_use(fx, OUTER_LIMIT) * dim_in_use(fy, PLANE_SIDE)
                   * dim_in_use(fz, PLANE_SIDE);
            count = grid * $urandom_range(1, 2) + $urandom_range(0, grid) + 1;
            if ($urandom_range(0, 3) == 0)
            begin
                split = $urandom_range(1, count - 1);
                queue_samples(split, FILL_RANDOM);
                wait_drained();
                if ($urandom_range(0, 1) == 1)
                    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                              $urandom_range(0, 2047));
                else
                    write_reg(fwr_pkg::REG_FINE_DIM_Z, fz);
                queue_samples(count - split, FILL_RANDOM);
            end
            else
                queue_samples(count, FILL_RANDOM);
            random_items += count;
        end

        wait_drained();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #(LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
